/* hdl/linear_regression_gradient_accumulator_unit_assert.svh */
// assertion macros shared by the gradient accumulator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef LINEAR_REGRESSION_GRADIENT_ACCUMULATOR_UNIT_ASSERT_SVH
`define LINEAR_REGRESSION_GRADIENT_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LRGA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lrga assertion failed");
`define LRGA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lrga forbidden condition");
`else
`define LRGA_ASSERT(lbl, clk, rst_n, prop)
`define LRGA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hdl/lrga_pkg.sv */
// shared constants, types and control struct for the gradient accumulator
// no dependencies; used by every module of the block
`default_nettype none
package lrga_pkg;

  localparam int FEATURE_COUNT = 6;
  localparam int DATA_W        = 16;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int PRED_W        = 35;
  localparam int ERR_W         = PRED_W - 8;
  localparam int GPROD_W       = ERR_W + DATA_W;
  localparam int GRAD_W        = 48;
  localparam int BIAS_ACC_W    = 40;
  localparam int SQ_W          = 2 * ERR_W - 1;
  localparam int COST_W        = 48;
  localparam int COUNT_W       = 16;
  localparam int CFG_IDX_W     = $clog2(FEATURE_COUNT + 1);

  localparam logic [CFG_IDX_W-1:0] REG_BIAS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = CFG_IDX_W'(1);

  localparam logic signed [DATA_W-1:0] BIAS_RESET     = DATA_W'(256);
  localparam logic signed [DATA_W-1:0] WEIGHT_0_RESET = DATA_W'(128);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ERR,
    S_GRAD,
    S_ACC
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic err_en;
    logic grad_en;
    logic acc_en;
    logic clear;
  } ctrl_t;

endpackage
`default_nettype wire

/* hdl/lrga_lane.sv */
// one feature lane: weight product, gradient product, saturating accumulator
// depends on lrga_pkg
`default_nettype none
module lrga_lane (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire lrga_pkg::ctrl_t                    ctrl_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0] weight_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0] feature_i,
  input  wire logic signed [lrga_pkg::ERR_W-1:0]  err_i,
  output logic signed [lrga_pkg::PROD_W-1:0]      prod_o,
  output logic signed [lrga_pkg::GRAD_W-1:0]      sum_o
);
  import lrga_pkg::*;

  logic signed [DATA_W-1:0]  x_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [GPROD_W-1:0] gprod_q, gprod_d;
  logic signed [GRAD_W-1:0]  acc_q, acc_d;
  logic signed [GRAD_W:0]    wide_sum;

  assign gprod_d = err_i * x_q;

  always_comb begin
    wide_sum = {acc_q[GRAD_W-1], acc_q} + (GRAD_W + 1)'(gprod_q);
    if (wide_sum[GRAD_W] != wide_sum[GRAD_W-1]) begin
      sum_o = {wide_sum[GRAD_W], {(GRAD_W - 1){~wide_sum[GRAD_W]}}};
    end else begin
      sum_o = wide_sum[GRAD_W-1:0];
    end
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else begin
      acc_d = sum_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= feature_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= weight_i * x_q;
    end
    if (ctrl_i.grad_en) begin
      gprod_q <= gprod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

/* hdl/lrga_merge.sv */
// merging stage: prediction sum, rounding, error, square, bias and cost sums
// depends on lrga_pkg
`default_nettype none
module lrga_merge (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire lrga_pkg::ctrl_t                    ctrl_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0] bias_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0] target_i,
  input  wire logic signed [lrga_pkg::PROD_W-1:0] prod_i [lrga_pkg::FEATURE_COUNT],
  output logic signed [lrga_pkg::ERR_W-1:0]       err_o,
  output logic signed [lrga_pkg::BIAS_ACC_W-1:0]  bias_sum_o,
  output logic        [lrga_pkg::COST_W-1:0]      cost_sum_o
);
  import lrga_pkg::*;

  logic signed [DATA_W-1:0]     target_q;
  logic signed [PRED_W-1:0]     pred, pred_rnd;
  logic signed [ERR_W:0]        err_full;
  logic signed [ERR_W-1:0]      err_q;
  logic signed [2*ERR_W-1:0]    sq_full;
  logic        [SQ_W-1:0]       sq_q;
  logic signed [BIAS_ACC_W:0]   bias_wide;
  logic signed [BIAS_ACC_W-1:0] bias_acc_q;
  logic        [SQ_W:0]         cost_wide;
  logic        [COST_W-1:0]     cost_acc_q;

  always_comb begin
    pred = {{(PRED_W - DATA_W - 8){bias_i[DATA_W-1]}}, bias_i, 8'h00};
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      pred = pred + PRED_W'(prod_i[j]);
    end
    pred_rnd = pred + PRED_W'(128);
    err_full = {pred_rnd[PRED_W-1], pred_rnd[PRED_W-1:8]} - (ERR_W + 1)'(target_q);
  end

  assign sq_full = err_q * err_q;

  always_comb begin
    bias_wide = {bias_acc_q[BIAS_ACC_W-1], bias_acc_q} + (BIAS_ACC_W + 1)'(err_q);
    if (bias_wide[BIAS_ACC_W] != bias_wide[BIAS_ACC_W-1]) begin
      bias_sum_o = {bias_wide[BIAS_ACC_W], {(BIAS_ACC_W - 1){~bias_wide[BIAS_ACC_W]}}};
    end else begin
      bias_sum_o = bias_wide[BIAS_ACC_W-1:0];
    end
    cost_wide = (SQ_W + 1)'(cost_acc_q) + (SQ_W + 1)'(sq_q);
    if (|cost_wide[SQ_W:COST_W]) begin
      cost_sum_o = '1;
    end else begin
      cost_sum_o = cost_wide[COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      target_q <= target_i;
    end
    if (ctrl_i.err_en) begin
      err_q <= err_full[ERR_W-1:0];
    end
    if (ctrl_i.grad_en) begin
      sq_q <= sq_full[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_acc_q <= '0;
      cost_acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      if (ctrl_i.clear) begin
        bias_acc_q <= '0;
        cost_acc_q <= '0;
      end else begin
        bias_acc_q <= bias_sum_o;
        cost_acc_q <= cost_sum_o;
      end
    end
  end

  assign err_o = err_q;

endmodule
`default_nettype wire

/* hdl/linear_regression_gradient_accumulator_unit.sv */
// Batch gradient accumulator for linear regression with a squared-error cost.
// Input channel (in_valid_i / in_ready_o): one training sample per transaction,
// six signed Q8.8 features, a Q8.8 target and a last_sample flag.
// Output channel (out_valid_o / out_ready_i): one transaction per batch, sent
// for the sample flagged last, with the saturated gradient sums, the error sum,
// the squared-error sum and the sample count; the sums then restart at zero.
// Configuration: cfg_we_i writes bias (index 0) or weight j (index j+1);
// other indexes are ignored. Write only while no sample is in flight.
// Each sample walks a four-step sequence shared by six feature lanes: weight
// multiply, prediction merge with rounding, error multiply, accumulate.
// A new sample is taken in the accumulate step of the previous one; the
// result is registered when the last sample's accumulate step commits.
// While a result waits on out_ready_i the next samples are still taken and
// summed; only a further last sample holds in its accumulate step until the
// output register frees up.
// Reset clears all sums and the count, drops out_valid_o and loads the default
// bias 1.0 and weights (0.5 for weight 0, zero for the rest).
// depends on lrga_pkg, lrga_lane, lrga_merge and the assertion header
`default_nettype none
`include "linear_regression_gradient_accumulator_unit_assert.svh"
module linear_regression_gradient_accumulator_unit (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        cfg_we_i,
  input  wire logic [lrga_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [lrga_pkg::DATA_W-1:0]           cfg_wdata_i,
  input  wire                                        in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [lrga_pkg::DATA_W-1:0]    feature_0_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0]    feature_1_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0]    feature_2_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0]    feature_3_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0]    feature_4_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0]    feature_5_i,
  input  wire logic signed [lrga_pkg::DATA_W-1:0]    target_i,
  input  wire                                        last_sample_i,
  output logic                                       out_valid_o,
  input  wire                                        out_ready_i,
  output logic signed [lrga_pkg::GRAD_W-1:0]         grad_feature_0_o,
  output logic signed [lrga_pkg::GRAD_W-1:0]         grad_feature_1_o,
  output logic signed [lrga_pkg::GRAD_W-1:0]         grad_feature_2_o,
  output logic signed [lrga_pkg::GRAD_W-1:0]         grad_feature_3_o,
  output logic signed [lrga_pkg::GRAD_W-1:0]         grad_feature_4_o,
  output logic signed [lrga_pkg::GRAD_W-1:0]         grad_feature_5_o,
  output logic signed [lrga_pkg::BIAS_ACC_W-1:0]     grad_bias_o,
  output logic        [lrga_pkg::COST_W-1:0]         squared_error_sum_o,
  output logic        [lrga_pkg::COUNT_W-1:0]        sample_count_o
);
  import lrga_pkg::*;

  state_e                   state_q, state_d;
  ctrl_t                    ctrl;
  logic                     accept, commit, last_q;
  logic signed [DATA_W-1:0] bias_q;
  logic signed [DATA_W-1:0] weight_q [FEATURE_COUNT];
  logic signed [DATA_W-1:0] feature [FEATURE_COUNT];
  logic signed [PROD_W-1:0] prod [FEATURE_COUNT];
  logic signed [GRAD_W-1:0] lane_sum [FEATURE_COUNT];
  logic signed [GRAD_W-1:0] grad_q [FEATURE_COUNT];
  logic signed [ERR_W-1:0]  err;
  logic signed [BIAS_ACC_W-1:0] bias_sum, grad_bias_q;
  logic        [COST_W-1:0] cost_sum, cost_q;
  logic        [COUNT_W-1:0] count_q, count_inc, count_out_q;
  logic                     out_valid_q;

  assign feature[0] = feature_0_i;
  assign feature[1] = feature_1_i;
  assign feature[2] = feature_2_i;
  assign feature[3] = feature_3_i;
  assign feature[4] = feature_4_i;
  assign feature[5] = feature_5_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= BIAS_RESET;
      for (int j = 0; j < FEATURE_COUNT; j++) begin
        weight_q[j] <= (j == 0) ? WEIGHT_0_RESET : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_BIAS) begin
        bias_q <= cfg_wdata_i;
      end
      for (int j = 0; j < FEATURE_COUNT; j++) begin
        if (cfg_index_i == REG_WEIGHT_0 + CFG_IDX_W'(j)) begin
          weight_q[j] <= cfg_wdata_i;
        end
      end
    end
  end

  // sequencer
  assign commit     = (state_q == S_ACC) && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) || commit;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ctrl.load    = accept;
    ctrl.mul_en  = 1'b0;
    ctrl.err_en  = 1'b0;
    ctrl.grad_en = 1'b0;
    ctrl.acc_en  = commit;
    ctrl.clear   = commit && last_q;
    state_d      = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        ctrl.mul_en = 1'b1;
        state_d     = S_ERR;
      end
      S_ERR: begin
        ctrl.err_en = 1'b1;
        state_d     = S_GRAD;
      end
      S_GRAD: begin
        ctrl.grad_en = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        if (accept) begin
          state_d = S_MUL;
        end else if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= last_sample_i;
    end
  end

  // feature lanes
  for (genvar g = 0; g < FEATURE_COUNT; g++) begin : g_lane
    lrga_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .weight_i  (weight_q[g]),
      .feature_i (feature[g]),
      .err_i     (err),
      .prod_o    (prod[g]),
      .sum_o     (lane_sum[g])
    );
  end

  lrga_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .bias_i     (bias_q),
    .target_i   (target_i),
    .prod_i     (prod),
    .err_o      (err),
    .bias_sum_o (bias_sum),
    .cost_sum_o (cost_sum)
  );

  // sample count
  assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit) begin
      count_q <= last_q ? '0 : count_inc;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && last_q) begin
      for (int j = 0; j < FEATURE_COUNT; j++) begin
        grad_q[j] <= lane_sum[j];
      end
      grad_bias_q <= bias_sum;
      cost_q      <= cost_sum;
      count_out_q <= count_inc;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign grad_feature_0_o    = grad_q[0];
  assign grad_feature_1_o    = grad_q[1];
  assign grad_feature_2_o    = grad_q[2];
  assign grad_feature_3_o    = grad_q[3];
  assign grad_feature_4_o    = grad_q[4];
  assign grad_feature_5_o    = grad_q[5];
  assign grad_bias_o         = grad_bias_q;
  assign squared_error_sum_o = cost_q;
  assign sample_count_o      = count_out_q;

  `LRGA_ASSERT(a_accept_starts_mul, clk_i, rst_ni, accept |=> state_q == S_MUL)
  `LRGA_ASSERT(a_last_holds_on_stall, clk_i, rst_ni,
      (state_q == S_ACC) && last_q && out_valid_q && !out_ready_i |=> state_q == S_ACC)
  `LRGA_ASSERT(a_count_clears_after_batch, clk_i, rst_ni, commit && last_q |=> count_q == '0)
  `LRGA_ASSERT_NEVER(a_result_not_empty, clk_i, rst_ni, out_valid_q && (count_out_q == '0))

endmodule
`default_nettype wire

/* tb/sv/tb_linear_regression_gradient_accumulator_unit.sv */
// self-checking testbench for the linear regression gradient accumulator
// drives samples, register writes and output stalls, predicts each batch result
// depends on lrga_pkg and linear_regression_gradient_accumulator_unit
`timescale 1ns / 1ps

module tb_linear_regression_gradient_accumulator_unit;
  import lrga_pkg::*;

  localparam int     CYCLE_LIMIT   = 2_000_000;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     RANDOM_PHASES = 16;
  localparam int     PHASE_SAMPLES = 40;
  localparam int     SAT_SAMPLES   = 200;
  localparam longint GRAD_MAX      = (longint'(1) <<< (GRAD_W - 1)) - 1;
  localparam longint GRAD_MIN      = -GRAD_MAX - 1;
  localparam longint BIAS_MAX      = (longint'(1) <<< (BIAS_ACC_W - 1)) - 1;
  localparam longint BIAS_MIN      = -BIAS_MAX - 1;
  localparam longint COST_MAX      = (longint'(1) <<< COST_W) - 1;
  localparam int     COUNT_MAX     = (1 << COUNT_W) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(FEATURE_COUNT + 1);

  typedef struct packed {
    logic [FEATURE_COUNT-1:0][DATA_W-1:0] feature;
    logic [DATA_W-1:0]                    target;
    logic                                 last;
  } sample_t;

  typedef struct packed {
    logic [FEATURE_COUNT-1:0][GRAD_W-1:0] grad;
    logic [BIAS_ACC_W-1:0]                grad_bias;
    logic [COST_W-1:0]                    sq_sum;
    logic [COUNT_W-1:0]                   count;
  } batch_sums_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    reg_value;
    sample_t              smp;
    logic                 typed;
    batch_sums_t          want;
  } stim_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 out_ready = 1'b0;
  sample_t              drv       = '0;
  wire                  in_ready;
  wire                  out_valid;
  wire [GRAD_W-1:0]     grad_out [FEATURE_COUNT];
  wire [BIAS_ACC_W-1:0] grad_bias_out;
  wire [COST_W-1:0]     sq_sum_out;
  wire [COUNT_W-1:0]    count_out;
  batch_sums_t          dut_sums;

  assign dut_sums = {grad_out[5], grad_out[4], grad_out[3], grad_out[2], grad_out[1],
                     grad_out[0], grad_bias_out, sq_sum_out, count_out};

  linear_regression_gradient_accumulator_unit u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .feature_0_i        (drv.feature[0]),
    .feature_1_i        (drv.feature[1]),
    .feature_2_i        (drv.feature[2]),
    .feature_3_i        (drv.feature[3]),
    .feature_4_i        (drv.feature[4]),
    .feature_5_i        (drv.feature[5]),
    .target_i           (drv.target),
    .last_sample_i      (drv.last),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .grad_feature_0_o   (grad_out[0]),
    .grad_feature_1_o   (grad_out[1]),
    .grad_feature_2_o   (grad_out[2]),
    .grad_feature_3_o   (grad_out[3]),
    .grad_feature_4_o   (grad_out[4]),
    .grad_feature_5_o   (grad_out[5]),
    .grad_bias_o        (grad_bias_out),
    .squared_error_sum_o(sq_sum_out),
    .sample_count_o     (count_out)
  );

  // predictor copy of the registers and the running sums
  logic [DATA_W-1:0] bias_reg;
  logic [DATA_W-1:0] weight_reg [FEATURE_COUNT];
  longint            feat_grad_sum [FEATURE_COUNT];
  longint            err_sum;
  longint            sq_err_sum;
  int                batch_count;

  batch_sums_t expected_sums [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;
  int          ready_run      = 0;
  bit          gaps_on        = 1'b1;
  bit          in_flight      = 1'b0;

  always #5 clk = ~clk;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic bit accumulate_sample(input sample_t s, output batch_sums_t sums);
    longint x;
    longint pred;
    longint err;
    pred = longint'($signed(bias_reg)) * 256;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      pred += longint'($signed(weight_reg[j])) * longint'($signed(s.feature[j]));
    end
    // round to q8.8, ties toward plus infinity
    pred = (pred + 128) >>> 8;
    err  = pred - longint'($signed(s.target));
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      x = longint'($signed(s.feature[j]));
      feat_grad_sum[j] = clamp(feat_grad_sum[j] + err * x, GRAD_MIN, GRAD_MAX);
    end
    err_sum    = clamp(err_sum + err, BIAS_MIN, BIAS_MAX);
    sq_err_sum = clamp(sq_err_sum + err * err, 0, COST_MAX);
    if (batch_count < COUNT_MAX) batch_count++;
    sums = '0;
    if (!s.last) return 1'b0;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      sums.grad[j]     = feat_grad_sum[j][GRAD_W-1:0];
      feat_grad_sum[j] = 0;
    end
    sums.grad_bias = err_sum[BIAS_ACC_W-1:0];
    sums.sq_sum    = sq_err_sum[COST_W-1:0];
    sums.count     = batch_count[COUNT_W-1:0];
    err_sum        = 0;
    sq_err_sum     = 0;
    batch_count    = 0;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_q88();
    int v;
    case ($urandom_range(0, 7))
      0: v = -32768;
      1: v = 32767;
      2: v = 0;
      3: v = -1;
      4, 5: v = $urandom_range(0, 1023) - 512;
      default: v = $urandom;
    endcase
    return v[DATA_W-1:0];
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_WRITE;
    r.reg_index = idx;
    r.reg_value = val[DATA_W-1:0];
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_sample(input int f0, f1, f2, f3, f4, f5, tgt, input bit last);
    stim_row_t r;
    r                = '0;
    r.kind           = ROW_SAMPLE;
    r.smp.feature[0] = f0[DATA_W-1:0];
    r.smp.feature[1] = f1[DATA_W-1:0];
    r.smp.feature[2] = f2[DATA_W-1:0];
    r.smp.feature[3] = f3[DATA_W-1:0];
    r.smp.feature[4] = f4[DATA_W-1:0];
    r.smp.feature[5] = f5[DATA_W-1:0];
    r.smp.target     = tgt[DATA_W-1:0];
    r.smp.last       = last;
    directed_rows = {directed_rows, r};
  endfunction

  // typed result for the newest row; only feature 0 is nonzero in those rows
  function automatic void expect_last(input longint g0, gb, sq, input int cnt);
    stim_row_t r;
    r                = directed_rows.pop_back();
    r.typed          = 1'b1;
    r.want           = '0;
    r.want.grad[0]   = g0[GRAD_W-1:0];
    r.want.grad_bias = gb[BIAS_ACC_W-1:0];
    r.want.sq_sum    = sq[COST_W-1:0];
    r.want.count     = cnt[COUNT_W-1:0];
    directed_rows = {directed_rows, r};
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want, got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic check_sums(input batch_sums_t got);
    batch_sums_t want;
    if (expected_sums.size() == 0) begin
      note_mismatch("unrequested transaction, sample_count", '0, got.count);
    end else begin
      want = expected_sums.pop_front();
      for (int j = 0; j < FEATURE_COUNT; j++) begin
        if (got.grad[j] !== want.grad[j]) begin
          note_mismatch($sformatf("grad_feature_%0d", j), want.grad[j], got.grad[j]);
        end
      end
      if (got.grad_bias !== want.grad_bias) begin
        note_mismatch("grad_bias", want.grad_bias, got.grad_bias);
      end
      if (got.sq_sum !== want.sq_sum) begin
        note_mismatch("squared_error_sum", want.sq_sum, got.sq_sum);
      end
      if (got.count !== want.count) begin
        note_mismatch("sample_count", want.count, got.count);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    in_flight = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    if (in_flight) settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BIAS) begin
      bias_reg = val;
    end else if (idx >= REG_WEIGHT_0 && idx < REG_WEIGHT_0 + FEATURE_COUNT) begin
      weight_reg[idx - REG_WEIGHT_0] = val;
    end
  endtask

  task automatic send_sample(input sample_t s, input bit typed, input batch_sums_t typed_sums);
    batch_sums_t sums;
    @(negedge clk);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    drv      <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_flight = 1'b1;
    if (accumulate_sample(s, sums)) begin
      expected_sums = {expected_sums, (typed ? typed_sums : sums)};
    end
  endtask

  task automatic send_repeated(input sample_t s, input int n);
    sample_t cur;
    cur      = s;
    cur.last = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) cur.last = 1'b1;
      send_sample(cur, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (ready_run == 0) begin
      out_ready <= ($urandom_range(0, 9) < 6);
      ready_run = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    ready_run--;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) check_sums(dut_sums);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    sample_t     smp;
    batch_sums_t none;
    int          sent;
    int          batch_len;

    none     = '0;
    bias_reg = BIAS_RESET;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      weight_reg[j]    = '0;
      feat_grad_sum[j] = 0;
    end
    weight_reg[0] = WEIGHT_0_RESET;
    err_sum       = 0;
    sq_err_sum    = 0;
    batch_count   = 0;

    // reset registers: bias 1.0, weight 0 at 0.5
    add_sample(0, 0, 0, 0, 0, 0, 0, 1'b1);
    expect_last(0, 256, 65536, 1);
    add_sample(256, 0, 0, 0, 0, 0, 0, 1'b1);
    expect_last(98304, 384, 147456, 1);
    // write to an unused index leaves the model unchanged
    add_write(REG_UNUSED, 16'h7f00);
    add_sample(256, 0, 0, 0, 0, 0, 384, 1'b1);
    expect_last(0, 0, 0, 1);
    // rounding ties go toward plus infinity
    add_write(REG_BIAS, 0);
    add_write(REG_WEIGHT_0, 1);
    add_sample(128, 0, 0, 0, 0, 0, 0, 1'b0);
    add_sample(-128, 0, 0, 0, 0, 0, 0, 1'b0);
    add_sample(-384, 0, 0, 0, 0, 0, 0, 1'b1);
    expect_last(512, 0, 2, 3);
    add_sample(0, 0, 0, 0, 0, 0, -32768, 1'b1);
    expect_last(0, 32768, 1073741824, 1);
    add_sample(0, 0, 0, 0, 0, 0, 32767, 1'b1);
    expect_last(0, -32767, 1073676289, 1);
    // extreme register settings
    add_write(REG_BIAS, 32767);
    for (int j = 0; j < FEATURE_COUNT; j++) add_write(CFG_IDX_W'(REG_WEIGHT_0 + j), -32768);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
    add_sample(-32768, 32767, -32768, 32767, -32768, 32767, 0, 1'b1);
    add_write(REG_BIAS, -32768);
    for (int j = 0; j < FEATURE_COUNT; j++) add_write(CFG_IDX_W'(REG_WEIGHT_0 + j), 32767);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
    add_sample(32767, -32768, 32767, -32768, 32767, -32768, 0, 1'b1);
    // one feature lane at a time
    add_write(REG_BIAS, 0);
    for (int j = 0; j < FEATURE_COUNT; j++) add_write(CFG_IDX_W'(REG_WEIGHT_0 + j), 64 * (j + 1));
    add_sample(256, 0, 0, 0, 0, 0, 0, 1'b0);
    add_sample(0, 256, 0, 0, 0, 0, 0, 1'b0);
    add_sample(0, 0, 256, 0, 0, 0, 0, 1'b0);
    add_sample(0, 0, 0, 256, 0, 0, 0, 1'b0);
    add_sample(0, 0, 0, 0, 256, 0, 0, 1'b0);
    add_sample(0, 0, 0, 0, 0, 256, 0, 1'b1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_reg(row.reg_index, row.reg_value);
      else send_sample(row.smp, row.typed, row.want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_BIAS, pick_q88());
      for (int j = 0; j < FEATURE_COUNT; j++) write_reg(CFG_IDX_W'(REG_WEIGHT_0 + j), pick_q88());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, DATA_W'($urandom));
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        batch_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int k = 0; k < batch_len; k++) begin
          for (int j = 0; j < FEATURE_COUNT; j++) smp.feature[j] = pick_q88();
          smp.target = pick_q88();
          smp.last   = (k == batch_len - 1);
          send_sample(smp, 1'b0, none);
        end
        sent += batch_len;
      end
    end

    // long batches drive the gradient and cost sums into saturation
    gaps_on = 1'b0;
    write_reg(REG_BIAS, 32767);
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      write_reg(CFG_IDX_W'(REG_WEIGHT_0 + j), (j < 3) ? 16'h8000 : 16'h7fff);
      smp.feature[j] = (j < 3) ? 16'h8000 : 16'h7fff;
    end
    smp.target = 16'h8000;
    send_repeated(smp, SAT_SAMPLES);
    write_reg(REG_BIAS, -32768);
    for (int j = 0; j < FEATURE_COUNT; j++) smp.feature[j] = (j < 3) ? 16'h7fff : 16'h8000;
    smp.target = 16'h7fff;
    send_repeated(smp, SAT_SAMPLES);

    settle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
